@@ hw/rtl/i2c_master_register_access_macros.svh @@
// assertion macros for the i2c register access master
`ifndef I2C_MASTER_REGISTER_ACCESS_MACROS_SVH
`define I2C_MASTER_REGISTER_ACCESS_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication, clocked on clk, off during reset
`define I2CM_ASSERT_IMPLY(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("i2cm check failed");
// next-cycle implication, clocked on clk, off during reset
`define I2CM_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("i2cm check failed");
`else
`define I2CM_ASSERT_IMPLY(label, ante, cons)
`define I2CM_ASSERT_NEXT(label, ante, cons)
`endif

`endif

@@ hw/rtl/i2cm_pkg.sv @@
// shared types and constants for the i2c register access master
`default_nettype none

package i2cm_pkg;

	localparam int unsigned PHASE_W = 16;
	localparam int unsigned LIMIT_W = 12;
	localparam int unsigned QUEUE_DEPTH = 2;

	// configuration register indexes
	localparam logic CFG_HALF_PHASE = 1'b0;
	localparam logic CFG_ACK_LIMIT  = 1'b1;

	localparam logic [PHASE_W-1:0] HALF_PHASE_RESET = 16'd1;
	localparam logic [LIMIT_W-1:0] ACK_LIMIT_RESET  = 12'd350;

	// opcodes
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_READ  = 1'b1;

	// bus sequence steps
	typedef enum logic [4:0] {
		STEP_IDLE     = 5'd0,
		STEP_START_A  = 5'd1,
		STEP_START_B  = 5'd2,
		STEP_START_C  = 5'd3,
		STEP_BIT_A    = 5'd4,
		STEP_BIT_B    = 5'd5,
		STEP_BIT_C    = 5'd6,
		STEP_TXE_A    = 5'd7,
		STEP_TXE_B    = 5'd8,
		STEP_ACK_A    = 5'd9,
		STEP_ACK_WAIT = 5'd10,
		STEP_ACK_END  = 5'd11,
		STEP_RX_A     = 5'd12,
		STEP_RX_B     = 5'd13,
		STEP_RX_C     = 5'd14,
		STEP_RX_D     = 5'd15,
		STEP_NAK_A    = 5'd16,
		STEP_NAK_B    = 5'd17,
		STEP_NAK_C    = 5'd18,
		STEP_STOP_A   = 5'd19,
		STEP_STOP_B   = 5'd20,
		STEP_STOP_C   = 5'd21
	} step_t;

	// which byte of the transaction is on the wire
	typedef enum logic [1:0] {
		STAGE_DEVICE   = 2'd0,
		STAGE_REGISTER = 2'd1,
		STAGE_THIRD    = 2'd2,
		STAGE_TAIL     = 2'd3
	} stage_t;

	// one tick as queued between front and sequencer
	typedef struct packed {
		logic       start_req;
		logic       opcode;
		logic [7:0] device_address;
		logic [7:0] register_address;
		logic [7:0] write_data;
		logic       sda_in;
	} tick_t;

	// queue to sequencer handoff
	typedef struct packed {
		logic  valid;
		tick_t tick;
	} tick_chan_t;

endpackage

`default_nettype wire

@@ hw/rtl/i2cm_front.sv @@
// input side: accepts ticks and holds them in a two-entry queue
`default_nettype none

module i2cm_front (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic                 request_valid,
	input  wire logic                 opcode,
	input  wire logic [7:0]           device_address,
	input  wire logic [7:0]           register_address,
	input  wire logic [7:0]           write_data,
	input  wire logic                 sda_in,
	output i2cm_pkg::tick_chan_t      q_out,
	input  wire logic                 q_pop
);

	i2cm_pkg::tick_t slot_q [i2cm_pkg::QUEUE_DEPTH];
	logic            wr_ptr_q;
	logic            rd_ptr_q;
	logic [1:0]      count_q;
	logic            push;
	logic            pop;

	// queue has room unless both slots hold ticks
	assign in_ready = (count_q != 2'd2);
	assign push     = in_valid && in_ready;
	assign pop      = q_pop && (count_q != 2'd0);

	assign q_out.valid = (count_q != 2'd0);
	assign q_out.tick  = slot_q[rd_ptr_q];

	// slot storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= '{start_req:        request_valid,
			                      opcode:           opcode,
			                      device_address:   device_address,
			                      register_address: register_address,
			                      write_data:       write_data,
			                      sda_in:           sda_in};
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop)  rd_ptr_q <= ~rd_ptr_q;
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/i2cm_seq.sv @@
// bus sequencer: one tick per cycle while the output is not stalled, result held in an output register
`default_nettype none

`include "i2c_master_register_access_macros.svh"

module i2cm_seq (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_write,
	input  wire logic                 cfg_index,
	input  wire logic [15:0]          cfg_data,
	input  wire i2cm_pkg::tick_chan_t q_in,
	output logic                      q_pop,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic                      scl_level,
	output logic                      sda_level,
	output logic                      busy_res,
	output logic                      done_res,
	output logic [7:0]                read_data,
	output logic                      ack_timeout
);

	logic [i2cm_pkg::PHASE_W-1:0] half_q;
	logic [i2cm_pkg::LIMIT_W-1:0] limit_q;

	i2cm_pkg::step_t              step_q, step_d;
	i2cm_pkg::stage_t             stage_q, stage_d;
	logic [3:0]                   bit_q, bit_d;
	logic [7:0]                   shift_q, shift_d;
	logic [i2cm_pkg::PHASE_W-1:0] timer_q, timer_d;
	logic [i2cm_pkg::LIMIT_W-1:0] ackcnt_q, ackcnt_d;
	logic [7:0]                   dev_q, dev_d;
	logic [7:0]                   reg_q, reg_d;
	logic [7:0]                   dat_q, dat_d;
	logic                         op_q, op_d;
	logic [7:0]                   rx_q, rx_d;
	logic                         tmo_q, tmo_d;
	logic                         scl_q, scl_d;
	logic                         sda_q, sda_d;
	logic                         done_d;

	logic                         out_valid_q;
	logic                         done_q;
	logic                         busy_q;

	logic                         fire;
	logic                         go;
	i2cm_pkg::step_t              tgt;
	logic [i2cm_pkg::PHASE_W-1:0] half_eff;
	logic [i2cm_pkg::LIMIT_W-1:0] limit_eff;
	logic [3:0]                   bit_inc;
	i2cm_pkg::tick_t              tk;

	assign tk        = q_in.tick;
	assign fire      = q_in.valid && (!out_valid_q || out_ready);
	assign q_pop     = fire;
	assign half_eff  = (half_q == '0) ? i2cm_pkg::PHASE_W'(1) : half_q;
	assign limit_eff = (limit_q == '0) ? i2cm_pkg::LIMIT_W'(1) : limit_q;
	assign bit_inc   = bit_q + 4'd1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_q  <= i2cm_pkg::HALF_PHASE_RESET;
			limit_q <= i2cm_pkg::ACK_LIMIT_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				i2cm_pkg::CFG_HALF_PHASE: half_q  <= cfg_data;
				i2cm_pkg::CFG_ACK_LIMIT:  limit_q <= cfg_data[i2cm_pkg::LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	// idle start, phase timer countdown, or at phase end the next step and byte state update
	always_comb begin
		step_d   = step_q;
		stage_d  = stage_q;
		bit_d    = bit_q;
		shift_d  = shift_q;
		timer_d  = timer_q;
		ackcnt_d = ackcnt_q;
		dev_d    = dev_q;
		reg_d    = reg_q;
		dat_d    = dat_q;
		op_d     = op_q;
		rx_d     = rx_q;
		tmo_d    = tmo_q;
		done_d   = 1'b0;
		go       = 1'b0;
		tgt      = i2cm_pkg::STEP_IDLE;
		if (fire) begin
			if (step_q == i2cm_pkg::STEP_IDLE) begin
				if (tk.start_req) begin
					dev_d   = tk.device_address;
					reg_d   = tk.register_address;
					dat_d   = tk.write_data;
					op_d    = tk.opcode;
					tmo_d   = 1'b0;
					stage_d = i2cm_pkg::STAGE_DEVICE;
					shift_d = tk.device_address;
					go      = 1'b1;
					tgt     = i2cm_pkg::STEP_START_A;
				end
			end else if (timer_q != '0) begin
				timer_d = timer_q - i2cm_pkg::PHASE_W'(1);
			end else begin
				case (step_q)
					i2cm_pkg::STEP_START_A: begin
						go = 1'b1; tgt = i2cm_pkg::STEP_START_B;
					end
					i2cm_pkg::STEP_START_B: begin
						go = 1'b1; tgt = i2cm_pkg::STEP_START_C;
					end
					i2cm_pkg::STEP_START_C: begin
						bit_d = 4'd0;
						go = 1'b1; tgt = i2cm_pkg::STEP_BIT_A;
					end
					i2cm_pkg::STEP_BIT_A: begin
						go = 1'b1; tgt = i2cm_pkg::STEP_BIT_B;
					end
					i2cm_pkg::STEP_BIT_B: begin
						go = 1'b1; tgt = i2cm_pkg::STEP_BIT_C;
					end
					i2cm_pkg::STEP_BIT_C: begin
						shift_d = {shift_q[6:0], 1'b0};
						bit_d   = bit_inc;
						go      = 1'b1;
						tgt     = (bit_inc < 4'd8) ? i2cm_pkg::STEP_BIT_A
						                           : i2cm_pkg::STEP_TXE_A;
					end
					i2cm_pkg::STEP_TXE_A: begin
						go = 1'b1; tgt = i2cm_pkg::STEP_TXE_B;
					end
					i2cm_pkg::STEP_TXE_B: begin
						go = 1'b1; tgt = i2cm_pkg::STEP_ACK_A;
					end
					i2cm_pkg::STEP_ACK_A: begin
						go = 1'b1;
						if (!tk.sda_in) begin
							tgt = i2cm_pkg::STEP_ACK_END;
						end else begin
							ackcnt_d = i2cm_pkg::LIMIT_W'(1);
							tgt      = i2cm_pkg::STEP_ACK_WAIT;
						end
					end
					i2cm_pkg::STEP_ACK_WAIT: begin
						go = 1'b1;
						if (ackcnt_q >= limit_eff) begin
							tmo_d = 1'b1;
							tgt   = i2cm_pkg::STEP_ACK_END;
						end else if (!tk.sda_in) begin
							tgt = i2cm_pkg::STEP_ACK_END;
						end else begin
							ackcnt_d = ackcnt_q + i2cm_pkg::LIMIT_W'(1);
							tgt      = i2cm_pkg::STEP_ACK_WAIT;
						end
					end
					i2cm_pkg::STEP_ACK_END: begin
						go = 1'b1;
						case (stage_q)
							i2cm_pkg::STAGE_DEVICE: begin
								stage_d = i2cm_pkg::STAGE_REGISTER;
								shift_d = reg_q;
								bit_d   = 4'd0;
								tgt     = i2cm_pkg::STEP_BIT_A;
							end
							i2cm_pkg::STAGE_REGISTER: begin
								stage_d = i2cm_pkg::STAGE_THIRD;
								if (op_q == i2cm_pkg::OP_WRITE) begin
									shift_d = dat_q;
									bit_d   = 4'd0;
									tgt     = i2cm_pkg::STEP_BIT_A;
								end else begin
									shift_d = dev_q + 8'd1;
									tgt     = i2cm_pkg::STEP_START_A;
								end
							end
							default: begin
								stage_d = i2cm_pkg::STAGE_TAIL;
								tgt     = (op_q == i2cm_pkg::OP_WRITE) ? i2cm_pkg::STEP_STOP_A
								                                       : i2cm_pkg::STEP_RX_A;
							end
						endcase
					end
					i2cm_pkg::STEP_RX_A: begin
						bit_d   = 4'd0;
						shift_d = 8'd0;
						go = 1'b1; tgt = i2cm_pkg::STEP_RX_B;
					end
					i2cm_pkg::STEP_RX_B: begin
						shift_d = {shift_q[6:0], tk.sda_in};
						go = 1'b1; tgt = i2cm_pkg::STEP_RX_C;
					end
					i2cm_pkg::STEP_RX_C: begin
						bit_d = bit_inc;
						go    = 1'b1;
						if (bit_inc < 4'd8) begin
							tgt = i2cm_pkg::STEP_RX_B;
						end else begin
							rx_d = shift_q;
							tgt  = i2cm_pkg::STEP_RX_D;
						end
					end
					i2cm_pkg::STEP_RX_D: begin
						go = 1'b1; tgt = i2cm_pkg::STEP_NAK_A;
					end
					i2cm_pkg::STEP_NAK_A: begin
						go = 1'b1; tgt = i2cm_pkg::STEP_NAK_B;
					end
					i2cm_pkg::STEP_NAK_B: begin
						go = 1'b1; tgt = i2cm_pkg::STEP_NAK_C;
					end
					i2cm_pkg::STEP_NAK_C: begin
						go = 1'b1; tgt = i2cm_pkg::STEP_STOP_A;
					end
					i2cm_pkg::STEP_STOP_A: begin
						go = 1'b1; tgt = i2cm_pkg::STEP_STOP_B;
					end
					i2cm_pkg::STEP_STOP_B: begin
						go = 1'b1; tgt = i2cm_pkg::STEP_STOP_C;
					end
					i2cm_pkg::STEP_STOP_C: begin
						step_d  = i2cm_pkg::STEP_IDLE;
						timer_d = '0;
						done_d  = 1'b1;
					end
					default: begin
						step_d  = i2cm_pkg::STEP_IDLE;
						timer_d = '0;
					end
				endcase
			end
		end
	end

	// step entry: drive the line change; the phase timer is reloaded in the state register
	always_comb begin
		scl_d = scl_q;
		sda_d = sda_q;
		if (go) begin
			case (tgt)
				i2cm_pkg::STEP_START_A: sda_d = 1'b1;
				i2cm_pkg::STEP_START_B: scl_d = 1'b1;
				i2cm_pkg::STEP_START_C: sda_d = 1'b0;
				i2cm_pkg::STEP_BIT_A:   scl_d = 1'b0;
				i2cm_pkg::STEP_BIT_B:   sda_d = shift_d[7];
				i2cm_pkg::STEP_BIT_C:   scl_d = 1'b1;
				i2cm_pkg::STEP_TXE_A:   scl_d = 1'b0;
				i2cm_pkg::STEP_TXE_B:   sda_d = 1'b1;
				i2cm_pkg::STEP_ACK_A:   scl_d = 1'b1;
				i2cm_pkg::STEP_ACK_END: scl_d = 1'b0;
				i2cm_pkg::STEP_RX_A:    scl_d = 1'b0;
				i2cm_pkg::STEP_RX_B: begin
					sda_d = 1'b1;
					scl_d = 1'b1;
				end
				i2cm_pkg::STEP_RX_C:    scl_d = 1'b0;
				i2cm_pkg::STEP_NAK_A:   sda_d = 1'b1;
				i2cm_pkg::STEP_NAK_B:   scl_d = 1'b1;
				i2cm_pkg::STEP_NAK_C:   scl_d = 1'b0;
				i2cm_pkg::STEP_STOP_A:  sda_d = 1'b0;
				i2cm_pkg::STEP_STOP_B:  scl_d = 1'b1;
				i2cm_pkg::STEP_STOP_C:  sda_d = 1'b1;
				default: ;
			endcase
		end
	end

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q   <= i2cm_pkg::STEP_IDLE;
			stage_q  <= i2cm_pkg::STAGE_DEVICE;
			bit_q    <= 4'd0;
			shift_q  <= 8'd0;
			timer_q  <= '0;
			ackcnt_q <= '0;
			dev_q    <= 8'd0;
			reg_q    <= 8'd0;
			dat_q    <= 8'd0;
			op_q     <= 1'b0;
			rx_q     <= 8'd0;
			tmo_q    <= 1'b0;
			scl_q    <= 1'b1;
			sda_q    <= 1'b1;
		end else if (fire) begin
			step_q   <= go ? tgt : step_d;
			stage_q  <= stage_d;
			bit_q    <= bit_d;
			shift_q  <= shift_d;
			timer_q  <= go ? (half_eff - i2cm_pkg::PHASE_W'(1)) : timer_d;
			ackcnt_q <= (go && (tgt == i2cm_pkg::STEP_ACK_A)) ? '0 : ackcnt_d;
			dev_q    <= dev_d;
			reg_q    <= reg_d;
			dat_q    <= dat_d;
			op_q     <= op_d;
			rx_q     <= rx_d;
			tmo_q    <= tmo_d;
			scl_q    <= scl_d;
			sda_q    <= sda_d;
		end
	end

	// result register, refilled on every tick taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			scl_level   <= scl_d;
			sda_level   <= sda_d;
			busy_q      <= go || (step_d != i2cm_pkg::STEP_IDLE);
			done_q      <= done_d;
			read_data   <= rx_d;
			ack_timeout <= tmo_d;
		end
	end

	assign out_valid = out_valid_q;
	assign busy_res  = busy_q;
	assign done_res  = done_q;

	// idle sequencer never holds a running phase timer
	`I2CM_ASSERT_IMPLY(a_idle_timer, step_q == i2cm_pkg::STEP_IDLE, timer_q == '0)
	// bit counter stays within one byte
	`I2CM_ASSERT_IMPLY(a_bit_range, 1'b1, bit_q <= 4'd8)
	// a completed stop shows up as done and no longer busy
	`I2CM_ASSERT_NEXT(a_stop_done,
		fire && step_q == i2cm_pkg::STEP_STOP_C && timer_q == '0,
		out_valid_q && done_q && !busy_q)
	// done only ever appears with the sequencer back at idle
	`I2CM_ASSERT_IMPLY(a_done_idle, out_valid_q && done_q, !busy_q)

endmodule

`default_nettype wire

@@ hw/rtl/i2c_master_register_access.sv @@
// top level of the tick-driven i2c register access master
//
//  channel | handshake            | payload
//  --------+----------------------+-----------------------------------------------
//  in      | in_valid / in_ready  | request_valid opcode device_address
//          |                      | register_address write_data sda_in
//  out     | out_valid/out_ready  | scl_level sda_level busy_res done_res
//          |                      | read_data ack_timeout
//  cfg     | cfg_write            | cfg_index cfg_data
//
// one tick is taken per cycle while the queue has room; its result passes through a queue slot and the result register
// the sequencer advances one tick per cycle while the output is not stalled, fed from a two-entry queue
// a stalled output holds the sequencer while the queue keeps taking up to two ticks
// reset leaves the sequencer idle with both lines high, half phase 1, ack limit 350
`default_nettype none

module i2c_master_register_access (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        request_valid,
	input  wire logic        opcode,
	input  wire logic [7:0]  device_address,
	input  wire logic [7:0]  register_address,
	input  wire logic [7:0]  write_data,
	input  wire logic        sda_in,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             scl_level,
	output logic             sda_level,
	output logic             busy_res,
	output logic             done_res,
	output logic [7:0]       read_data,
	output logic             ack_timeout,
	input  wire logic        cfg_write,
	input  wire logic        cfg_index,
	input  wire logic [15:0] cfg_data
);

	i2cm_pkg::tick_chan_t q_chan;
	logic                 q_pop;

	// input queue
	i2cm_front u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.request_valid    (request_valid),
		.opcode           (opcode),
		.device_address   (device_address),
		.register_address (register_address),
		.write_data       (write_data),
		.sda_in           (sda_in),
		.q_out            (q_chan),
		.q_pop            (q_pop)
	);

	// bus sequencer
	i2cm_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_write   (cfg_write),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.q_in        (q_chan),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.scl_level   (scl_level),
		.sda_level   (sda_level),
		.busy_res    (busy_res),
		.done_res    (done_res),
		.read_data   (read_data),
		.ack_timeout (ack_timeout)
	);

endmodule

`default_nettype wire

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// self-checking testbench for the tick-driven i2c register access master

module tb;

	localparam int CYCLE_LIMIT = 200000;
	localparam int RANDOM_END  = 1150;

	// data line behavior of the simulated slave on filler ticks
	localparam int SDA_LOW        = 0;
	localparam int SDA_HIGH       = 1;
	localparam int SDA_COIN       = 2;
	localparam int SDA_MOSTLY_LOW = 3;

	typedef struct {
		logic       req;
		logic       op;
		logic [7:0] dev;
		logic [7:0] regad;
		logic [7:0] wdata;
		logic       sda;
	} bus_tick_t;

	typedef struct {
		logic       scl;
		logic       sda;
		logic       busy;
		logic       done;
		logic [7:0] rdata;
		logic       tmo;
	} line_state_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        request_valid = 1'b0;
	logic        opcode = i2cm_pkg::OP_WRITE;
	logic [7:0]  device_address = 8'h00;
	logic [7:0]  register_address = 8'h00;
	logic [7:0]  write_data = 8'h00;
	logic        sda_in = 1'b1;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        scl_level;
	logic        sda_level;
	logic        busy_res;
	logic        done_res;
	logic [7:0]  read_data;
	logic        ack_timeout;
	logic        cfg_write = 1'b0;
	logic        cfg_index = i2cm_pkg::CFG_HALF_PHASE;
	logic [15:0] cfg_data = 16'h0000;

	i2c_master_register_access uut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.request_valid    (request_valid),
		.opcode           (opcode),
		.device_address   (device_address),
		.register_address (register_address),
		.write_data       (write_data),
		.sda_in           (sda_in),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.scl_level        (scl_level),
		.sda_level        (sda_level),
		.busy_res         (busy_res),
		.done_res         (done_res),
		.read_data        (read_data),
		.ack_timeout      (ack_timeout),
		.cfg_write        (cfg_write),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data)
	);

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// bookkeeping
	bus_tick_t   tick_queue[$];
	line_state_t lines_due[$];
	bus_tick_t   drive_tick;
	bit          idle_on = 1'b1;
	int          in_gap = 0;
	int          out_gap = 0;
	int          cycle_count = 0;
	int          fail_count = 0;
	int          n_checked = 0;
	int          n_started = 0;
	int          n_reads = 0;
	int          n_timeouts = 0;
	int          n_settings = 1;
	int          n_pushed = 0;

	// bus master shadow state and its copy of the registers
	i2cm_pkg::step_t  seq_step = i2cm_pkg::STEP_IDLE;
	i2cm_pkg::stage_t byte_stage = i2cm_pkg::STAGE_DEVICE;
	logic [3:0]  seq_bit = '0;
	logic [7:0]  seq_shift = '0;
	logic [15:0] seq_timer = '0;
	logic [11:0] ack_waits = '0;
	logic [7:0]  hold_dev = '0;
	logic [7:0]  hold_reg = '0;
	logic [7:0]  hold_data = '0;
	logic        hold_op = i2cm_pkg::OP_WRITE;
	logic [7:0]  rx_byte = '0;
	logic        tmo_flag = 1'b0;
	logic        scl_drv = 1'b1;
	logic        sda_drv = 1'b1;
	logic [15:0] half_cfg = i2cm_pkg::HALF_PHASE_RESET;
	logic [11:0] limit_cfg = i2cm_pkg::ACK_LIMIT_RESET;

	// enter a line phase: apply its line change and load the phase timer
	function automatic void enter_phase(input i2cm_pkg::step_t s);
		logic [15:0] h;
		h = (half_cfg == 16'd0) ? 16'd1 : half_cfg;
		seq_step = s;
		seq_timer = h - 16'd1;
		case (s)
			i2cm_pkg::STEP_START_A: sda_drv = 1'b1;
			i2cm_pkg::STEP_START_B: scl_drv = 1'b1;
			i2cm_pkg::STEP_START_C: sda_drv = 1'b0;
			i2cm_pkg::STEP_BIT_A: scl_drv = 1'b0;
			i2cm_pkg::STEP_BIT_B: sda_drv = seq_shift[7];
			i2cm_pkg::STEP_BIT_C: scl_drv = 1'b1;
			i2cm_pkg::STEP_TXE_A: scl_drv = 1'b0;
			i2cm_pkg::STEP_TXE_B: sda_drv = 1'b1;
			i2cm_pkg::STEP_ACK_A: begin
				scl_drv = 1'b1;
				ack_waits = '0;
			end
			i2cm_pkg::STEP_ACK_WAIT, i2cm_pkg::STEP_RX_D: ;
			i2cm_pkg::STEP_ACK_END: scl_drv = 1'b0;
			i2cm_pkg::STEP_RX_A: scl_drv = 1'b0;
			i2cm_pkg::STEP_RX_B: begin
				sda_drv = 1'b1;
				scl_drv = 1'b1;
			end
			i2cm_pkg::STEP_RX_C: scl_drv = 1'b0;
			i2cm_pkg::STEP_NAK_A: sda_drv = 1'b1;
			i2cm_pkg::STEP_NAK_B: scl_drv = 1'b1;
			i2cm_pkg::STEP_NAK_C: scl_drv = 1'b0;
			i2cm_pkg::STEP_STOP_A: sda_drv = 1'b0;
			i2cm_pkg::STEP_STOP_B: scl_drv = 1'b1;
			i2cm_pkg::STEP_STOP_C: sda_drv = 1'b1;
			default: begin
				seq_step = i2cm_pkg::STEP_IDLE;
				seq_timer = '0;
			end
		endcase
	endfunction

	function automatic void send_byte(input logic [7:0] v);
		seq_shift = v;
		seq_bit = '0;
		enter_phase(i2cm_pkg::STEP_BIT_A);
	endfunction

	// last tick of a phase; returns 1 when the stop condition completes
	function automatic logic close_phase(input logic sda);
		logic [11:0] lim;
		logic        fin;
		lim = (limit_cfg == 12'd0) ? 12'd1 : limit_cfg;
		fin = 1'b0;
		case (seq_step)
			i2cm_pkg::STEP_START_A: enter_phase(i2cm_pkg::STEP_START_B);
			i2cm_pkg::STEP_START_B: enter_phase(i2cm_pkg::STEP_START_C);
			i2cm_pkg::STEP_START_C: begin
				seq_bit = '0;
				enter_phase(i2cm_pkg::STEP_BIT_A);
			end
			i2cm_pkg::STEP_BIT_A: enter_phase(i2cm_pkg::STEP_BIT_B);
			i2cm_pkg::STEP_BIT_B: enter_phase(i2cm_pkg::STEP_BIT_C);
			i2cm_pkg::STEP_BIT_C: begin
				seq_shift = seq_shift << 1;
				seq_bit = seq_bit + 4'd1;
				if (seq_bit < 4'd8)
					enter_phase(i2cm_pkg::STEP_BIT_A);
				else
					enter_phase(i2cm_pkg::STEP_TXE_A);
			end
			i2cm_pkg::STEP_TXE_A: enter_phase(i2cm_pkg::STEP_TXE_B);
			i2cm_pkg::STEP_TXE_B: enter_phase(i2cm_pkg::STEP_ACK_A);
			i2cm_pkg::STEP_ACK_A: begin
				if (!sda) begin
					enter_phase(i2cm_pkg::STEP_ACK_END);
				end else begin
					ack_waits = 12'd1;
					enter_phase(i2cm_pkg::STEP_ACK_WAIT);
				end
			end
			// limit is checked before the line is looked at again
			i2cm_pkg::STEP_ACK_WAIT: begin
				if (ack_waits >= lim) begin
					tmo_flag = 1'b1;
					n_timeouts++;
					enter_phase(i2cm_pkg::STEP_ACK_END);
				end else if (!sda) begin
					enter_phase(i2cm_pkg::STEP_ACK_END);
				end else begin
					ack_waits = ack_waits + 12'd1;
					enter_phase(i2cm_pkg::STEP_ACK_WAIT);
				end
			end
			i2cm_pkg::STEP_ACK_END: begin
				case (byte_stage)
					i2cm_pkg::STAGE_DEVICE: begin
						byte_stage = i2cm_pkg::STAGE_REGISTER;
						send_byte(hold_reg);
					end
					i2cm_pkg::STAGE_REGISTER: begin
						byte_stage = i2cm_pkg::STAGE_THIRD;
						if (hold_op == i2cm_pkg::OP_WRITE) begin
							send_byte(hold_data);
						end else begin
							// repeated start with the read device byte
							seq_shift = hold_dev + 8'd1;
							enter_phase(i2cm_pkg::STEP_START_A);
						end
					end
					default: begin
						byte_stage = i2cm_pkg::STAGE_TAIL;
						if (hold_op == i2cm_pkg::OP_WRITE)
							enter_phase(i2cm_pkg::STEP_STOP_A);
						else
							enter_phase(i2cm_pkg::STEP_RX_A);
					end
				endcase
			end
			i2cm_pkg::STEP_RX_A: begin
				seq_bit = '0;
				seq_shift = '0;
				enter_phase(i2cm_pkg::STEP_RX_B);
			end
			i2cm_pkg::STEP_RX_B: begin
				seq_shift = {seq_shift[6:0], sda};
				enter_phase(i2cm_pkg::STEP_RX_C);
			end
			i2cm_pkg::STEP_RX_C: begin
				seq_bit = seq_bit + 4'd1;
				if (seq_bit < 4'd8) begin
					enter_phase(i2cm_pkg::STEP_RX_B);
				end else begin
					rx_byte = seq_shift;
					n_reads++;
					enter_phase(i2cm_pkg::STEP_RX_D);
				end
			end
			i2cm_pkg::STEP_RX_D: enter_phase(i2cm_pkg::STEP_NAK_A);
			i2cm_pkg::STEP_NAK_A: enter_phase(i2cm_pkg::STEP_NAK_B);
			i2cm_pkg::STEP_NAK_B: enter_phase(i2cm_pkg::STEP_NAK_C);
			i2cm_pkg::STEP_NAK_C: enter_phase(i2cm_pkg::STEP_STOP_A);
			i2cm_pkg::STEP_STOP_A: enter_phase(i2cm_pkg::STEP_STOP_B);
			i2cm_pkg::STEP_STOP_B: enter_phase(i2cm_pkg::STEP_STOP_C);
			i2cm_pkg::STEP_STOP_C: begin
				seq_step = i2cm_pkg::STEP_IDLE;
				seq_timer = '0;
				fin = 1'b1;
			end
			default: begin
				seq_step = i2cm_pkg::STEP_IDLE;
				seq_timer = '0;
			end
		endcase
		return fin;
	endfunction

	// advance the shadow master by one tick and queue the line state it yields
	function automatic void step_master(input bus_tick_t t);
		line_state_t r;
		logic        fin;
		fin = 1'b0;
		if (seq_step == i2cm_pkg::STEP_IDLE) begin
			if (t.req) begin
				hold_dev = t.dev;
				hold_reg = t.regad;
				hold_data = t.wdata;
				hold_op = t.op;
				tmo_flag = 1'b0;
				byte_stage = i2cm_pkg::STAGE_DEVICE;
				seq_shift = t.dev;
				n_started++;
				enter_phase(i2cm_pkg::STEP_START_A);
			end
		end else if (seq_timer != 16'd0) begin
			seq_timer = seq_timer - 16'd1;
		end else begin
			fin = close_phase(t.sda);
		end
		r.scl = scl_drv;
		r.sda = sda_drv;
		r.busy = (seq_step != i2cm_pkg::STEP_IDLE);
		r.done = fin;
		r.rdata = rx_byte;
		r.tmo = tmo_flag;
		lines_due.push_back(r);
	endfunction

	task automatic report_mismatch(input string msg);
		fail_count++;
		if (fail_count <= 40)
			$display("mismatch at result %0d: %s", n_checked, msg);
	endtask

	// compare one accepted result with the oldest expectation
	task automatic check_result();
		line_state_t w;
		if (lines_due.size() == 0) begin
			report_mismatch("result arrived with nothing expected");
			return;
		end
		w = lines_due.pop_front();
		if (scl_level !== w.scl)
			report_mismatch($sformatf("scl_level %b, expected %b", scl_level, w.scl));
		if (sda_level !== w.sda)
			report_mismatch($sformatf("sda_level %b, expected %b", sda_level, w.sda));
		if (busy_res !== w.busy)
			report_mismatch($sformatf("busy_res %b, expected %b", busy_res, w.busy));
		if (done_res !== w.done)
			report_mismatch($sformatf("done_res %b, expected %b", done_res, w.done));
		if (read_data !== w.rdata)
			report_mismatch($sformatf("read_data %h, expected %h", read_data, w.rdata));
		if (ack_timeout !== w.tmo)
			report_mismatch($sformatf("ack_timeout %b, expected %b", ack_timeout, w.tmo));
		n_checked++;
	endtask

	// tick driver with random idle bursts
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_gap = 0;
		end else begin
			if (in_valid && in_ready)
				step_master(drive_tick);
			if (!in_valid || in_ready) begin
				if (in_gap > 0) begin
					in_gap--;
					in_valid <= 1'b0;
				end else if (idle_on && $urandom_range(0, 7) == 0) begin
					in_gap = int'($urandom_range(0, 10));
					in_valid <= 1'b0;
				end else if (tick_queue.size() != 0) begin
					drive_tick = tick_queue.pop_front();
					in_valid <= 1'b1;
					request_valid <= drive_tick.req;
					opcode <= drive_tick.op;
					device_address <= drive_tick.dev;
					register_address <= drive_tick.regad;
					write_data <= drive_tick.wdata;
					sda_in <= drive_tick.sda;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor with random stall bursts
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			out_gap = 0;
		end else begin
			if (out_valid && out_ready)
				check_result();
			if (out_gap > 0) begin
				out_gap--;
				out_ready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				out_gap = int'($urandom_range(0, 10));
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// watchdog
	always @(posedge clk)
		cycle_count <= cycle_count + 1;

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("timeout after %0d cycles, %0d results pending", cycle_count, lines_due.size());
		$display("i2c_master_register_access test failed");
		$finish;
	end

	function automatic bus_tick_t make_tick(input int sda_mode, input int noise_pct);
		bus_tick_t t;
		t.req = ($urandom_range(0, 99) < noise_pct);
		t.op = $urandom_range(0, 1) ? i2cm_pkg::OP_READ : i2cm_pkg::OP_WRITE;
		t.dev = 8'($urandom_range(0, 255));
		t.regad = 8'($urandom_range(0, 255));
		t.wdata = 8'($urandom_range(0, 255));
		case (sda_mode)
			SDA_LOW: t.sda = 1'b0;
			SDA_HIGH: t.sda = 1'b1;
			SDA_COIN: t.sda = 1'($urandom_range(0, 1));
			default: t.sda = ($urandom_range(0, 4) == 0);
		endcase
		return t;
	endfunction

	task automatic push_filler(input int n, input int sda_mode, input int noise_pct);
		repeat (n) begin
			tick_queue.push_back(make_tick(sda_mode, noise_pct));
			n_pushed++;
		end
	endtask

	task automatic push_request(input logic op, input logic [7:0] dev, input logic [7:0] regad,
		input logic [7:0] wdata, input int sda_mode, input int filler, input int noise_pct);
		bus_tick_t t;
		t = make_tick(sda_mode, 0);
		t.req = 1'b1;
		t.op = op;
		t.dev = dev;
		t.regad = regad;
		t.wdata = wdata;
		tick_queue.push_back(t);
		n_pushed++;
		push_filler(filler, sda_mode, noise_pct);
	endtask

	// wait until every queued tick has been answered
	task automatic wait_drained();
		do @(negedge clk);
		while (tick_queue.size() != 0 || in_valid || lines_due.size() != 0);
		repeat (8) @(negedge clk);
	endtask

	// run quiet ticks until the shadow master is back to idle
	task automatic settle_bus();
		int h;
		while (seq_step != i2cm_pkg::STEP_IDLE) begin
			h = (half_cfg == 16'd0) ? 1 : int'(half_cfg);
			push_filler(int'(seq_timer) + 64 * h, SDA_LOW, 0);
			wait_drained();
		end
	endtask

	task automatic set_register(input logic idx, input logic [15:0] v);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		cfg_write <= 1'b0;
		if (idx == i2cm_pkg::CFG_HALF_PHASE)
			half_cfg = v;
		else
			limit_cfg = v[11:0];
		n_settings++;
		@(negedge clk);
	endtask

	// stimulus
	initial begin
		int          n_txn;
		int          heff;
		int          fill;
		int          mode;
		logic        op;
		logic [15:0] hv;
		logic [15:0] lv;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: reset settings, field extremes, both operations
		push_request(i2cm_pkg::OP_WRITE, 8'hFF, 8'hFF, 8'hFF, SDA_LOW, 92, 0);
		push_request(i2cm_pkg::OP_READ, 8'h00, 8'hFF, 8'h00, SDA_LOW, 116, 0);
		wait_drained();
		settle_bus();
		// no acknowledge at all: every wait times out, device byte wraps
		set_register(i2cm_pkg::CFG_ACK_LIMIT, 16'd3);
		push_request(i2cm_pkg::OP_READ, 8'hFF, 8'h00, 8'hFF, SDA_HIGH, 128, 0);
		wait_drained();
		settle_bus();
		// requests on every tick: while busy, on the done tick, back to back
		push_request(i2cm_pkg::OP_WRITE, 8'hA5, 8'h3C, 8'hC3, SDA_LOW, 100, 100);
		wait_drained();
		settle_bus();

		// zero phase length and zero limit, limit written with upper bits set
		set_register(i2cm_pkg::CFG_HALF_PHASE, 16'd0);
		set_register(i2cm_pkg::CFG_ACK_LIMIT, 16'hF000);
		push_request(i2cm_pkg::OP_READ, 8'h7E, 8'h18, 8'h66, SDA_COIN, 120, 0);
		wait_drained();
		settle_bus();

		// random settings and transactions
		while (n_pushed < RANDOM_END) begin
			case ($urandom_range(0, 9))
				0: hv = 16'd0;
				1, 2, 3, 4, 5, 6: hv = 16'd1;
				7, 8: hv = 16'd2;
				default: hv = 16'd3;
			endcase
			case ($urandom_range(0, 9))
				0, 1, 2, 3: lv = 16'($urandom_range(1, 3));
				4, 5, 6: lv = 16'($urandom_range(4, 40));
				7: lv = 16'd4095;
				8: lv = 16'd350;
				default: lv = 16'($urandom_range(1, 4095));
			endcase
			set_register(i2cm_pkg::CFG_HALF_PHASE, hv);
			set_register(i2cm_pkg::CFG_ACK_LIMIT, lv);
			idle_on = ($urandom_range(0, 3) != 0);
			heff = (hv == 16'd0) ? 1 : int'(hv);
			n_txn = int'($urandom_range(1, 2));
			repeat (n_txn) begin
				op = $urandom_range(0, 1) ? i2cm_pkg::OP_READ : i2cm_pkg::OP_WRITE;
				case ($urandom_range(0, 9))
					0, 1, 2: mode = SDA_LOW;
					3, 4, 5, 6: mode = SDA_MOSTLY_LOW;
					7, 8: mode = SDA_COIN;
					default: mode = (lv <= 16'd3) ? SDA_HIGH : SDA_COIN;
				endcase
				fill = ((op == i2cm_pkg::OP_READ) ? 116 : 92) * heff
					+ int'($urandom_range(0, 8));
				// a short gap makes the next request land while still busy
				if ($urandom_range(0, 3) == 0)
					fill = fill / 2;
				push_request(op, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
					8'($urandom_range(0, 255)), mode, fill,
					$urandom_range(0, 1) ? 0 : 5);
			end
			wait_drained();
			settle_bus();
		end

		// closing read at the reset settings with no idling
		idle_on = 1'b0;
		set_register(i2cm_pkg::CFG_HALF_PHASE, 16'd1);
		set_register(i2cm_pkg::CFG_ACK_LIMIT, 16'd350);
		push_request(i2cm_pkg::OP_READ, 8'hC3, 8'h3C, 8'h99, SDA_MOSTLY_LOW, 116, 0);
		wait_drained();
		settle_bus();

		wait_drained();
		repeat (20) @(negedge clk);
		$display("ran %0d transactions (%0d reads) over %0d register settings, %0d ticks",
			n_started, n_reads, n_settings, n_pushed);
		$display("compared %0d results, %0d acknowledge timeouts seen", n_checked, n_timeouts);
		if (fail_count == 0)
			$display("i2c_master_register_access test passed");
		else
			$display("i2c_master_register_access test failed");
		$finish;
	end

endmodule

@@ i2c_master_register_access.f @@
+incdir+hw/rtl
hw/rtl/i2cm_pkg.sv
hw/rtl/i2cm_front.sv
hw/rtl/i2cm_seq.sv
hw/rtl/i2c_master_register_access.sv
tb/tb.sv
